[sv/ffa_pkg.sv]
// Shared types and constants of the first-fit free-list allocator.
// Used by the interfaces, the controller, the datapath and the top level.
package ffa_pkg;

    localparam int HEAP_WORDS = 16384;
    localparam int HEAP_AW    = $clog2(HEAP_WORDS);
    localparam int CNT_W      = $clog2(HEAP_WORDS + 1);
    localparam int IDX_W      = 36;
    localparam int BYTES_W    = 17;
    localparam int ASZ_W      = 16;

    typedef logic [31:0]      word_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t  HEAP_LIM  = IDX_W'(HEAP_WORDS);
    localparam word_t INIT_WORD = 32'(0 - HEAP_WORDS);

    typedef enum logic [5:0] {
        OP_NONE,
        OP_CLR,
        OP_LATCH,
        OP_A_INIT,
        OP_RD_T,
        OP_CAP_H,
        OP_RD_TAIL,
        OP_RD_LINK,
        OP_FOLLOW,
        OP_WH_HDR,
        OP_WH_FTR,
        OP_SP_HDR,
        OP_SP_FTR,
        OP_SP_AHDR,
        OP_SP_AFTR,
        OP_U_RD1,
        OP_U_RD2,
        OP_U_CAPN,
        OP_U_FIX,
        OP_U_FIX2,
        OP_R_CHK,
        OP_R_CAPS,
        OP_R_RDFTR,
        OP_R_WHDR,
        OP_R_WFTR,
        OP_R_PNEXT,
        OP_R_PPREV,
        OP_R_PHEAD,
        OP_R_RDH,
        OP_R_CAPR,
        OP_R_RDR,
        OP_R_SETJ,
        OP_L_RD,
        OP_L_CAPF,
        OP_L_RDB,
        OP_J_RD,
        OP_J_CAP,
        OP_J_RDR,
        OP_J_SUM,
        OP_J_WHDR,
        OP_J_WFTR,
        OP_FIN_OK,
        OP_FIN_BASE,
        OP_FIN_FAIL
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic clr_last;
        logic is_release;
        logic zero_bytes;
        logic walk_end;
        logic fit;
        logic whole;
        logic pv;
        logic nv;
        logic rel_bad;
        logic size_bad;
        logic ftr_mismatch;
        logic rd_neg;
        logic r_in_heap;
        logic hdr_zero;
        logic left_ok;
        logic out_free;
    } stat_t;

endpackage

[sv/ffa_if.sv]
// Request and response channel interfaces of the allocator.
// Depends on ffa_pkg for the field widths.
interface ffa_in_if import ffa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               action;
    logic [BYTES_W-1:0] request_bytes;
    logic [31:0]        release_address;

    modport source (output valid, output action, output request_bytes,
                    output release_address, input ready);
    modport sink   (input valid, input action, input request_bytes,
                    input release_address, output ready);
endinterface

interface ffa_out_if ();
    logic        valid;
    logic        ready;
    logic [31:0] address;
    logic        ok;

    modport source (output valid, output address, output ok, input ready);
    modport sink   (input valid, input address, input ok, output ready);
endinterface

[sv/ffa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/ffa_ctl.sv]
// Sequencer of the allocator: steps the datapath through clearing,
// allocation walks, releases, merges and list unlinks. Depends on ffa_pkg.
module ffa_ctl import ffa_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_DISP,
        S_A0, S_A_LOOP, S_A_HDR, S_A_TEST, S_A_NEXT, S_A_WH1, S_A_WH2,
        S_A_SP2, S_A_SP3, S_A_SP4,
        S_U1, S_U2, S_U3, S_U4, S_U5,
        S_R0, S_R_CAPS, S_R_TST, S_R_CMP, S_R_WFTR, S_R_PNEXT, S_R_PPREV,
        S_R_PHEAD, S_R_RDH, S_R_CAPR, S_R_RCHK, S_R_RTST,
        S_L1, S_L2, S_L3, S_L4,
        S_J1, S_J2, S_J3, S_J4, S_J5, S_J6,
        S_FIN_OK, S_FIN_BASE, S_FIN_FAIL
    } state_t;

    typedef enum logic [1:0] {
        CTX_ALLOC,
        CTX_RIGHT,
        CTX_LEFT
    } ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        cmd.op     = OP_NONE;
        cmd.accept = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.accept = 1'b1;
                if (st.in_valid)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:     state_next = st.is_release ? S_R0 : S_A0;
            S_A0:
            begin
                if (st.zero_bytes)
                begin
                    state_next = S_FIN_BASE;
                end
                else
                begin
                    cmd.op     = OP_A_INIT;
                    state_next = S_A_LOOP;
                end
            end
            S_A_LOOP:
            begin
                if (st.walk_end)
                begin
                    state_next = S_FIN_FAIL;
                end
                else
                begin
                    cmd.op     = OP_RD_T;
                    state_next = S_A_HDR;
                end
            end
            S_A_HDR:
            begin
                cmd.op     = OP_CAP_H;
                state_next = S_A_TEST;
            end
            S_A_TEST:
            begin
                if (st.fit && st.whole)
                begin
                    cmd.op     = OP_RD_TAIL;
                    state_next = S_A_WH1;
                end
                else if (st.fit)
                begin
                    cmd.op     = OP_SP_HDR;
                    state_next = S_A_SP2;
                end
                else
                begin
                    cmd.op     = OP_RD_LINK;
                    state_next = S_A_NEXT;
                end
            end
            S_A_NEXT:
            begin
                cmd.op     = OP_FOLLOW;
                state_next = S_A_LOOP;
            end
            S_A_WH1:
            begin
                cmd.op     = OP_WH_HDR;
                state_next = S_A_WH2;
            end
            S_A_WH2:
            begin
                cmd.op     = OP_WH_FTR;
                ctx_next   = CTX_ALLOC;
                state_next = S_U1;
            end
            S_A_SP2:
            begin
                cmd.op     = OP_SP_FTR;
                state_next = S_A_SP3;
            end
            S_A_SP3:
            begin
                cmd.op     = OP_SP_AHDR;
                state_next = S_A_SP4;
            end
            S_A_SP4:
            begin
                cmd.op     = OP_SP_AFTR;
                state_next = S_FIN_OK;
            end
            S_U1:
            begin
                cmd.op     = OP_U_RD1;
                state_next = S_U2;
            end
            S_U2:
            begin
                cmd.op     = OP_U_RD2;
                state_next = S_U3;
            end
            S_U3:
            begin
                cmd.op     = OP_U_CAPN;
                state_next = S_U4;
            end
            S_U4, S_U5:
            begin
                cmd.op = (state_reg == S_U4) ? OP_U_FIX : OP_U_FIX2;
                if (state_reg == S_U4 && st.pv && st.nv)
                begin
                    state_next = S_U5;
                end
                else if (ctx_reg == CTX_RIGHT)
                begin
                    state_next = S_L1;
                end
                else
                begin
                    state_next = S_FIN_OK;
                end
            end
            S_R0:
            begin
                if (st.rel_bad)
                begin
                    state_next = S_FIN_FAIL;
                end
                else
                begin
                    cmd.op     = OP_R_CHK;
                    state_next = S_R_CAPS;
                end
            end
            S_R_CAPS:
            begin
                cmd.op     = OP_R_CAPS;
                state_next = S_R_TST;
            end
            S_R_TST:
            begin
                if (st.size_bad)
                begin
                    state_next = S_FIN_FAIL;
                end
                else
                begin
                    cmd.op     = OP_R_RDFTR;
                    state_next = S_R_CMP;
                end
            end
            S_R_CMP:
            begin
                if (st.ftr_mismatch)
                begin
                    state_next = S_FIN_FAIL;
                end
                else
                begin
                    cmd.op     = OP_R_WHDR;
                    state_next = S_R_WFTR;
                end
            end
            S_R_WFTR:
            begin
                cmd.op     = OP_R_WFTR;
                state_next = S_R_PNEXT;
            end
            S_R_PNEXT:
            begin
                cmd.op     = OP_R_PNEXT;
                state_next = S_R_PPREV;
            end
            S_R_PPREV:
            begin
                cmd.op     = OP_R_PPREV;
                state_next = S_R_PHEAD;
            end
            S_R_PHEAD:
            begin
                cmd.op     = OP_R_PHEAD;
                state_next = S_R_RDH;
            end
            S_R_RDH:
            begin
                cmd.op     = OP_R_RDH;
                state_next = S_R_CAPR;
            end
            S_R_CAPR:
            begin
                cmd.op     = OP_R_CAPR;
                state_next = S_R_RCHK;
            end
            S_R_RCHK:
            begin
                if (st.r_in_heap)
                begin
                    cmd.op     = OP_R_RDR;
                    state_next = S_R_RTST;
                end
                else
                begin
                    state_next = S_L1;
                end
            end
            S_R_RTST:
            begin
                if (st.rd_neg)
                begin
                    cmd.op     = OP_R_SETJ;
                    ctx_next   = CTX_RIGHT;
                    state_next = S_J1;
                end
                else
                begin
                    state_next = S_L1;
                end
            end
            S_L1:
            begin
                if (st.hdr_zero)
                begin
                    state_next = S_FIN_OK;
                end
                else
                begin
                    cmd.op     = OP_L_RD;
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                cmd.op     = OP_L_CAPF;
                state_next = S_L3;
            end
            S_L3:
            begin
                if (st.left_ok)
                begin
                    cmd.op     = OP_L_RDB;
                    state_next = S_L4;
                end
                else
                begin
                    state_next = S_FIN_OK;
                end
            end
            S_L4:
            begin
                if (st.rd_neg)
                begin
                    ctx_next   = CTX_LEFT;
                    state_next = S_J1;
                end
                else
                begin
                    state_next = S_FIN_OK;
                end
            end
            S_J1:
            begin
                cmd.op     = OP_J_RD;
                state_next = S_J2;
            end
            S_J2:
            begin
                cmd.op     = OP_J_CAP;
                state_next = S_J3;
            end
            S_J3:
            begin
                cmd.op     = OP_J_RDR;
                state_next = S_J4;
            end
            S_J4:
            begin
                cmd.op     = OP_J_SUM;
                state_next = S_J5;
            end
            S_J5:
            begin
                cmd.op     = OP_J_WHDR;
                state_next = S_J6;
            end
            S_J6:
            begin
                cmd.op     = OP_J_WFTR;
                state_next = S_U1;
            end
            S_FIN_OK, S_FIN_BASE, S_FIN_FAIL:
            begin
                // The result register must be free before it is loaded.
                if (st.out_free)
                begin
                    case (state_reg)
                        S_FIN_OK:   cmd.op = OP_FIN_OK;
                        S_FIN_BASE: cmd.op = OP_FIN_BASE;
                        default:    cmd.op = OP_FIN_FAIL;
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ctx_reg   <= CTX_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

endmodule

[sv/ffa_dp.sv]
// Datapath of the allocator: heap memory, work registers, free-list head
// and result register, driven one step per cycle. Depends on ffa_pkg,
// ffa_if and ffa_ram.
module ffa_dp import ffa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    ffa_in_if.sink       req,
    ffa_out_if.source    rsp,
    input  cmd_t         cmd,
    output stat_t        st
);

    function automatic idx_t mag_w(input word_t w);
        logic [32:0] x;
        logic [32:0] n;
        begin
            x = {w[31], w};
            n = 33'd0 - x;
            mag_w = x[32] ? IDX_W'(n) : IDX_W'(x);
        end
    endfunction

    function automatic idx_t mag_s(input logic [32:0] s);
        logic [33:0] x;
        logic [33:0] n;
        begin
            x = {s[32], s};
            n = 34'd0 - x;
            mag_s = x[33] ? IDX_W'(n) : IDX_W'(x);
        end
    endfunction

    function automatic word_t neg_idx(input idx_t v);
        idx_t n;
        begin
            n = IDX_W'(0) - v;
            neg_idx = n[31:0];
        end
    endfunction

    function automatic word_t link_of(input idx_t v);
        link_of = {1'b1, v[30:0]};
    endfunction

    // Control state.
    logic [30:0]      head_reg, head_next;
    logic             empty_reg, empty_next;
    logic [31:0]      base_reg, base_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_oob_reg;

    // Work registers.
    logic               action_reg, action_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [31:0]        rel_reg, rel_next;
    logic [ASZ_W-1:0]   asize_reg, asize_next;
    idx_t               t_reg, t_next;
    idx_t               a_reg, a_next;
    idx_t               u_reg, u_next;
    idx_t               hh_reg, hh_next;
    idx_t               keep_reg, keep_next;
    word_t              h_reg, h_next;
    word_t              w_reg, w_next;
    word_t              s_reg, s_next;
    word_t              p_reg, p_next;
    word_t              n_reg, n_next;
    logic [32:0]        sum_reg, sum_next;
    logic               valid_reg, valid_next;
    logic [31:0]        res_addr_reg, res_addr_next;
    logic [31:0]        out_addr_reg, out_addr_next;
    logic               out_ok_reg, out_ok_next;

    // Memory access.
    idx_t  mem_idx;
    idx_t  rd_idx;
    logic  mem_we;
    word_t mem_wd;
    word_t ram_q;
    word_t rdata;

    // Derived values.
    logic [BYTES_W:0] bytes_up;
    logic [ASZ_W-1:0] asize_c;
    idx_t             keep_c;
    logic [32:0]      rel_d;
    idx_t             rel_h;
    idx_t             asz_idx;

    ffa_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .clk   (clk),
        .we    (mem_we && (mem_idx < HEAP_LIM)),
        .waddr (mem_idx[HEAP_AW-1:0]),
        .wdata (mem_wd),
        .raddr (rd_idx[HEAP_AW-1:0]),
        .rdata (ram_q)
    );

    // A read outside the heap returns zero.
    assign rdata = rd_oob_reg ? '0 : ram_q;

    assign bytes_up = {1'b0, bytes_reg} + (BYTES_W + 1)'(3);
    assign asize_c  = (bytes_up[BYTES_W:2] < ASZ_W'(2)) ? ASZ_W'(2)
                                                         : ASZ_W'(bytes_up[BYTES_W:2]);
    assign asz_idx  = IDX_W'(asize_reg);
    assign keep_c   = a_reg - asz_idx - IDX_W'(2);
    assign rel_d    = {1'b0, rel_reg} - {1'b0, base_reg};
    assign rel_h    = IDX_W'(rel_d[31:2]) - IDX_W'(1);

    function automatic logic [31:0] payload(input idx_t hdr, input logic [31:0] base);
        idx_t p1;
        begin
            p1 = hdr + IDX_W'(1);
            payload = base + {p1[29:0], 2'b00};
        end
    endfunction

    always_comb
    begin
        head_next      = head_reg;
        empty_next     = empty_reg;
        base_next      = cfg_we ? cfg_wdata : base_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        cnt_next       = cnt_reg;
        action_next    = action_reg;
        bytes_next     = bytes_reg;
        rel_next       = rel_reg;
        asize_next     = asize_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        u_next         = u_reg;
        hh_next        = hh_reg;
        keep_next      = keep_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        sum_next       = sum_reg;
        valid_next     = valid_reg;
        res_addr_next  = res_addr_reg;
        out_addr_next  = out_addr_reg;
        out_ok_next    = out_ok_reg;
        mem_idx        = t_reg;
        rd_idx         = t_reg;
        mem_we         = 1'b0;
        mem_wd         = '0;
        case (cmd.op)
            OP_CLR:
            begin
                mem_idx  = IDX_W'(cnt_reg);
                mem_we   = 1'b1;
                mem_wd   = (cnt_reg == '0 || cnt_reg == CNT_W'(HEAP_WORDS - 1))
                           ? INIT_WORD : '0;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_LATCH:
            begin
                action_next   = req.action;
                bytes_next    = req.request_bytes;
                rel_next      = req.release_address;
                res_addr_next = '0;
            end
            OP_A_INIT:
            begin
                asize_next = asize_c;
                t_next     = IDX_W'(head_reg);
                valid_next = !empty_reg;
                cnt_next   = '0;
            end
            OP_RD_T:    rd_idx = t_reg;
            OP_CAP_H:
            begin
                h_next = rdata;
                a_next = mag_w(rdata);
            end
            OP_RD_TAIL: rd_idx = t_reg + a_reg - IDX_W'(1);
            OP_RD_LINK: rd_idx = t_reg + IDX_W'(2);
            OP_FOLLOW:
            begin
                valid_next = rdata[31];
                t_next     = IDX_W'(rdata[30:0]);
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            OP_WH_HDR:
            begin
                w_next  = rdata;
                mem_idx = t_reg;
                mem_we  = 1'b1;
                mem_wd  = 32'd0 - h_reg;
            end
            OP_WH_FTR:
            begin
                mem_idx       = t_reg + a_reg - IDX_W'(1);
                mem_we        = 1'b1;
                mem_wd        = 32'd0 - w_reg;
                res_addr_next = payload(t_reg, base_reg);
                u_next        = t_reg;
            end
            OP_SP_HDR:
            begin
                keep_next = keep_c;
                mem_idx   = t_reg;
                mem_we    = 1'b1;
                mem_wd    = neg_idx(keep_c);
            end
            OP_SP_FTR:
            begin
                mem_idx = t_reg + keep_reg - IDX_W'(1);
                mem_we  = 1'b1;
                mem_wd  = neg_idx(keep_reg);
            end
            OP_SP_AHDR:
            begin
                mem_idx = t_reg + keep_reg;
                mem_we  = 1'b1;
                mem_wd  = 32'(asz_idx + IDX_W'(2));
            end
            OP_SP_AFTR:
            begin
                mem_idx       = t_reg + keep_reg + asz_idx + IDX_W'(1);
                mem_we        = 1'b1;
                mem_wd        = 32'(asz_idx + IDX_W'(2));
                res_addr_next = payload(t_reg + keep_reg, base_reg);
            end
            OP_U_RD1:   rd_idx = u_reg + IDX_W'(1);
            OP_U_RD2:
            begin
                p_next = rdata;
                rd_idx = u_reg + IDX_W'(2);
            end
            OP_U_CAPN:  n_next = rdata;
            OP_U_FIX:
            begin
                case ({p_reg[31], n_reg[31]})
                    2'b01:
                    begin
                        head_next  = n_reg[30:0];
                        empty_next = 1'b0;
                        mem_idx    = IDX_W'(n_reg[30:0]) + IDX_W'(1);
                        mem_we     = 1'b1;
                        mem_wd     = '0;
                    end
                    2'b11:
                    begin
                        mem_idx = IDX_W'(p_reg[30:0]) + IDX_W'(2);
                        mem_we  = 1'b1;
                        mem_wd  = n_reg;
                    end
                    2'b00:
                    begin
                        head_next  = '0;
                        empty_next = 1'b1;
                    end
                    default:
                    begin
                        mem_idx = IDX_W'(p_reg[30:0]) + IDX_W'(2);
                        mem_we  = 1'b1;
                        mem_wd  = '0;
                    end
                endcase
            end
            OP_U_FIX2:
            begin
                mem_idx = IDX_W'(n_reg[30:0]) + IDX_W'(1);
                mem_we  = 1'b1;
                mem_wd  = p_reg;
            end
            OP_R_CHK:
            begin
                hh_next = rel_h;
                rd_idx  = rel_h;
            end
            OP_R_CAPS:  s_next = rdata;
            OP_R_RDFTR: rd_idx = hh_reg + IDX_W'(s_reg) - IDX_W'(1);
            OP_R_WHDR:
            begin
                mem_idx = hh_reg;
                mem_we  = 1'b1;
                mem_wd  = 32'd0 - s_reg;
            end
            OP_R_WFTR:
            begin
                mem_idx = hh_reg + IDX_W'(s_reg) - IDX_W'(1);
                mem_we  = 1'b1;
                mem_wd  = 32'd0 - s_reg;
            end
            OP_R_PNEXT:
            begin
                mem_idx = hh_reg + IDX_W'(2);
                mem_we  = 1'b1;
                mem_wd  = empty_reg ? '0 : {1'b1, head_reg};
            end
            OP_R_PPREV:
            begin
                mem_idx = hh_reg + IDX_W'(1);
                mem_we  = 1'b1;
                mem_wd  = '0;
            end
            OP_R_PHEAD:
            begin
                mem_idx    = IDX_W'(head_reg) + IDX_W'(1);
                mem_we     = !empty_reg;
                mem_wd     = link_of(hh_reg);
                head_next  = hh_reg[30:0];
                empty_next = 1'b0;
            end
            OP_R_RDH:   rd_idx = hh_reg;
            OP_R_CAPR:  u_next = hh_reg + mag_w(rdata);
            OP_R_RDR:   rd_idx = u_reg;
            OP_R_SETJ:  t_next = hh_reg;
            OP_L_RD:    rd_idx = hh_reg - IDX_W'(1);
            OP_L_CAPF:  a_next = mag_w(rdata);
            OP_L_RDB:
            begin
                rd_idx = hh_reg - a_reg;
                t_next = hh_reg - a_reg;
            end
            OP_J_RD:    rd_idx = t_reg;
            OP_J_CAP:
            begin
                w_next = rdata;
                u_next = t_reg + mag_w(rdata);
            end
            OP_J_RDR:   rd_idx = u_reg;
            OP_J_SUM:   sum_next = {w_reg[31], w_reg} + {rdata[31], rdata};
            OP_J_WHDR:
            begin
                mem_idx = t_reg;
                mem_we  = 1'b1;
                mem_wd  = sum_reg[31:0];
            end
            OP_J_WFTR:
            begin
                // A zero-sized merge points at the word before the block; that
                // write is dropped by the range check only at the heap start.
                mem_idx = t_reg + mag_s(sum_reg) - IDX_W'(1);
                mem_we  = 1'b1;
                mem_wd  = sum_reg[31:0];
            end
            OP_FIN_OK:
            begin
                out_valid_next = 1'b1;
                out_addr_next  = res_addr_reg;
                out_ok_next    = 1'b1;
            end
            OP_FIN_BASE:
            begin
                out_valid_next = 1'b1;
                out_addr_next  = base_reg;
                out_ok_next    = 1'b1;
            end
            OP_FIN_FAIL:
            begin
                out_valid_next = 1'b1;
                out_addr_next  = '0;
                out_ok_next    = 1'b0;
            end
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            empty_reg     <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rd_oob_reg    <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            rd_oob_reg    <= (rd_idx >= HEAP_LIM);
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        bytes_reg    <= bytes_next;
        rel_reg      <= rel_next;
        asize_reg    <= asize_next;
        t_reg        <= t_next;
        a_reg        <= a_next;
        u_reg        <= u_next;
        hh_reg       <= hh_next;
        keep_reg     <= keep_next;
        h_reg        <= h_next;
        w_reg        <= w_next;
        s_reg        <= s_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        sum_reg      <= sum_next;
        valid_reg    <= valid_next;
        res_addr_reg <= res_addr_next;
        out_addr_reg <= out_addr_next;
        out_ok_reg   <= out_ok_next;
    end

    assign req.ready   = cmd.accept;
    assign rsp.valid   = out_valid_reg;
    assign rsp.address = out_addr_reg;
    assign rsp.ok      = out_ok_reg;

    always_comb
    begin
        st.in_valid     = req.valid;
        st.clr_last     = (cnt_reg == CNT_W'(HEAP_WORDS - 1));
        st.is_release   = action_reg;
        st.zero_bytes   = (bytes_reg == '0);
        st.walk_end     = !valid_reg || (cnt_reg == CNT_W'(HEAP_WORDS));
        st.fit          = (asz_idx + IDX_W'(2)) <= a_reg;
        st.whole        = (asz_idx + IDX_W'(6)) >= a_reg;
        st.pv           = p_reg[31];
        st.nv           = n_reg[31];
        st.rel_bad      = (rel_reg == '0) || rel_d[32] || (rel_d[31:0] < 32'd4)
                          || (rel_d[1:0] != 2'b00) || (rel_h >= HEAP_LIM);
        st.size_bad     = s_reg[31] || (s_reg < 32'd4)
                          || (IDX_W'(s_reg) > (HEAP_LIM - hh_reg));
        st.ftr_mismatch = (rdata != s_reg);
        st.rd_neg       = rdata[31];
        st.r_in_heap    = (u_reg < HEAP_LIM);
        st.hdr_zero     = (hh_reg == '0);
        st.left_ok      = (a_reg != '0) && (a_reg <= hh_reg);
        st.out_free     = !out_valid_reg || rsp.ready;
    end

endmodule

[sv/first_fit_free_list_allocator.sv]
// Heap allocator with boundary tags and a first-fit free list, one request
// word at a time. Depends on ffa_pkg, ffa_if, ffa_ctl and ffa_dp.
//
// After reset the block runs a clearing pass over all HEAP_WORDS (16384)
// words of the heap memory before it takes its first request; configuration
// writes are accepted during that pass. Each word is handled to completion
// before the next is taken, since every step goes through the one write
// port and the one read port of the heap memory. An allocation walks the
// free list node by node and then splits or hands over the block found;
// a zero-byte request needs no walk. A release that is acted on may merge
// with its right and left neighbors. A finished result sits in an output
// register, so a new request is taken while it waits to be read.
module first_fit_free_list_allocator import ffa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    ffa_in_if.sink      req,
    ffa_out_if.source   rsp
);

    cmd_t  cmd;
    stat_t st;

    ffa_ctl u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    ffa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

[sv/ffa_checker.sv]
// Port-level checks on the allocator, attached to the top level by bind.
// Depends only on the ports of first_fit_free_list_allocator.
module ffa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_address,
    input logic        out_ok
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] open_reg, open_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        open_next = open_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // No more than one word in work and one result waiting.
    a_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (open_reg == 2'd0 || open_reg == 2'd1))
        else $error("request taken with two words outstanding");

    // Every result belongs to an accepted request.
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (open_reg != 2'd0))
        else $error("result without a request");

    // The heap clearing pass keeps requests out right after reset.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request taken during heap clearing");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before taken");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_address) && $stable(out_ok))
        else $error("stalled result changed");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_address (rsp.address),
    .out_ok      (rsp.ok)
);

[test/tb_first_fit_free_list_allocator.sv]
// Self-checking testbench of the first-fit free-list allocator.
// Depends on ffa_pkg, ffa_if and the allocator top level. A software image of the
// heap predicts every response; the phases vary the base address, idling and stalls.
module tb_first_fit_free_list_allocator;
    import ffa_pkg::*;

    localparam int    WATCHDOG_LIMIT = 200000;
    localparam int    ERR_PRINT_MAX  = 40;
    localparam logic  ACT_ALLOC      = 1'b0;
    localparam logic  ACT_RELEASE    = 1'b1;

    typedef struct {
        logic [31:0] address;
        logic        ok;
    } grant_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [31:0] cfg_wdata;

    ffa_in_if  req ();
    ffa_out_if rsp ();

    first_fit_free_list_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req.sink),
        .rsp      (rsp.source)
    );

    // Software image of the heap and its bookkeeping.
    logic [31:0] heap_img [HEAP_WORDS];
    longint      list_head;
    logic        no_free;
    logic [31:0] base_reg;

    grant_t  grants_due [$];
    longint  live_blocks [$];
    longint  freed_blocks [$];
    int      err_count;
    int      idle_pct;
    int      stall_pct;
    int      quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] heap_rd(longint i);
        if (i < 0 || i >= HEAP_WORDS)
            return 32'd0;
        return heap_img[i];
    endfunction

    function automatic void heap_wr(longint i, logic [31:0] v);
        if (i >= 0 && i < HEAP_WORDS)
            heap_img[i] = v;
    endfunction

    function automatic longint tag_at(longint i);
        return longint'($signed(heap_rd(i)));
    endfunction

    function automatic longint magn(longint s);
        return (s < 0) ? -s : s;
    endfunction

    function automatic void put_tags(longint i, longint s);
        heap_wr(i, 32'(s));
        heap_wr(i + magn(s) - 1, 32'(s));
    endfunction

    function automatic logic [31:0] link_to(longint i);
        return {1'b1, 31'(i)};
    endfunction

    function automatic void list_remove(longint t);
        logic [31:0] p;
        logic [31:0] n;
        p = heap_rd(t + 1);
        n = heap_rd(t + 2);
        if (!p[31] && n[31])
        begin
            list_head = longint'(n[30:0]);
            no_free = 1'b0;
            heap_wr(longint'(n[30:0]) + 1, 32'd0);
        end
        else if (p[31] && n[31])
        begin
            heap_wr(longint'(p[30:0]) + 2, n);
            heap_wr(longint'(n[30:0]) + 1, p);
        end
        else if (!p[31] && !n[31])
        begin
            list_head = 0;
            no_free = 1'b1;
        end
        else
            heap_wr(longint'(p[30:0]) + 2, 32'd0);
    endfunction

    function automatic void list_push(longint t);
        heap_wr(t + 2, no_free ? 32'd0 : link_to(list_head));
        heap_wr(t + 1, 32'd0);
        if (!no_free)
            heap_wr(list_head + 1, link_to(t));
        list_head = t;
        no_free = 1'b0;
    endfunction

    function automatic void merge_next(longint t);
        longint r;
        longint s;
        r = t + magn(tag_at(t));
        s = tag_at(t) + tag_at(r);
        put_tags(t, s);
        list_remove(r);
    endfunction

    function automatic logic [31:0] payload_of(longint hdr);
        return base_reg + 32'((hdr + 1) * 4);
    endfunction

    // Returns the header of the granted block in hdr, or -1.
    function automatic logic first_fit(logic [BYTES_W-1:0] bytes, output logic [31:0] addr,
                                       output longint hdr);
        longint want;
        longint t;
        longint a;
        longint keep;
        longint hs;
        longint fs;
        logic [31:0] l;
        logic more;
        addr = 32'd0;
        hdr = -1;
        if (bytes == 0)
        begin
            addr = base_reg;
            return 1'b1;
        end
        want = (longint'(bytes) + 3) >> 2;
        if (want < 2)
            want = 2;
        more = !no_free;
        t = list_head;
        for (int n = 0; more && n < HEAP_WORDS; n++)
        begin
            a = magn(tag_at(t));
            if (want <= a - 2)
            begin
                if (want >= a - 6)
                begin
                    hs = tag_at(t);
                    fs = tag_at(t + a - 1);
                    heap_wr(t, 32'(-hs));
                    heap_wr(t + a - 1, 32'(-fs));
                    list_remove(t);
                    hdr = t;
                end
                else
                begin
                    keep = a - want - 2;
                    put_tags(t, -keep);
                    put_tags(t + keep, want + 2);
                    hdr = t + keep;
                end
                addr = payload_of(hdr);
                return 1'b1;
            end
            l = heap_rd(t + 2);
            more = l[31];
            t = longint'(l[30:0]);
        end
        return 1'b0;
    endfunction

    function automatic logic give_back(logic [31:0] p, output longint hdr);
        longint d;
        longint s;
        longint r;
        longint f;
        hdr = -1;
        if (p == 0)
            return 1'b0;
        d = longint'(p) - longint'(base_reg);
        if (d < 4 || (d % 4) != 0)
            return 1'b0;
        hdr = d / 4 - 1;
        if (hdr >= HEAP_WORDS)
            return 1'b0;
        s = tag_at(hdr);
        if (s < 4 || s > HEAP_WORDS - hdr)
            return 1'b0;
        if (heap_rd(hdr + s - 1) != heap_rd(hdr))
            return 1'b0;
        put_tags(hdr, -s);
        list_push(hdr);
        r = hdr + magn(tag_at(hdr));
        if (r < HEAP_WORDS && tag_at(r) < 0)
            merge_next(hdr);
        if (hdr > 0)
        begin
            f = magn(tag_at(hdr - 1));
            if (f > 0 && f <= hdr && tag_at(hdr - f) < 0)
                merge_next(hdr - f);
        end
        return 1'b1;
    endfunction

    function automatic void heap_reset_image();
        foreach (heap_img[i])
            heap_img[i] = 32'd0;
        put_tags(0, -HEAP_WORDS);
        list_head = 0;
        no_free = 1'b0;
        base_reg = 32'd0;
    endfunction

    // Works out the response of one accepted word and updates the block lists.
    function automatic void predict_word(logic act, logic [BYTES_W-1:0] bytes,
                                         logic [31:0] rel);
        grant_t g;
        longint hdr;
        if (act == ACT_ALLOC)
        begin
            g.ok = first_fit(bytes, g.address, hdr);
            if (g.ok && hdr >= 0)
                live_blocks.push_back(hdr);
        end
        else
        begin
            g.address = 32'd0;
            g.ok = give_back(rel, hdr);
            if (g.ok)
            begin
                foreach (live_blocks[i])
                    if (live_blocks[i] == hdr)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                freed_blocks.push_back(hdr);
                if (freed_blocks.size() > 64)
                    void'(freed_blocks.pop_front());
            end
        end
        grants_due.push_back(g);
    endfunction

    task automatic send_word(logic act, logic [BYTES_W-1:0] bytes, logic [31:0] rel);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.action <= act;
        req.request_bytes <= bytes;
        req.release_address <= rel;
        do
            @(posedge clk);
        while (!req.ready);
        predict_word(act, bytes, rel);
    endtask

    task automatic stop_sending();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_base(logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        base_reg = value;
    endtask

    function automatic logic [31:0] live_addr();
        return payload_of(live_blocks[$urandom_range(live_blocks.size() - 1)]);
    endfunction

    task automatic test_directed();
        longint hdr;
        send_word(ACT_ALLOC, 17'd0, 32'd0);
        send_word(ACT_ALLOC, 17'd65536, 32'd0);
        send_word(ACT_ALLOC, 17'd65528, 32'hFFFF_FFFF);
        send_word(ACT_ALLOC, 17'd1, 32'd0);
        send_word(ACT_RELEASE, 17'h1FFFF, payload_of(16376));
        send_word(ACT_ALLOC, 17'd65520, 32'd0);
        send_word(ACT_ALLOC, 17'd4, 32'd0);
        send_word(ACT_ALLOC, 17'd9, 32'd0);
        send_word(ACT_ALLOC, 17'd100, 32'd0);
        send_word(ACT_RELEASE, 17'd0, 32'd0);
        send_word(ACT_RELEASE, 17'd0, 32'd2);
        send_word(ACT_RELEASE, 17'd0, payload_of(10) + 32'd1);
        send_word(ACT_RELEASE, 17'd0, payload_of(HEAP_WORDS));
        send_word(ACT_RELEASE, 17'd0, 32'hFFFF_FFFF);
        send_word(ACT_RELEASE, 17'd0, payload_of(0));
        // Release the middle block first, then its neighbors, so both merges happen.
        while (live_blocks.size() > 0)
        begin
            hdr = live_blocks[live_blocks.size() / 2];
            send_word(ACT_RELEASE, 17'd0, payload_of(hdr));
        end
        send_word(ACT_RELEASE, 17'd0, payload_of(hdr));
        send_word(ACT_ALLOC, 17'd65528, 32'd0);
        stop_sending();
    endtask

    task automatic test_random(int count, int idle, int stall);
        int pick;
        logic [31:0] a;
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45 && live_blocks.size() < 120)
                send_word(ACT_ALLOC, 17'($urandom_range(1, 160)), $urandom);
            else if (pick < 85 && live_blocks.size() > 0)
                send_word(ACT_RELEASE, 17'($urandom), live_addr());
            else if (pick < 89)
                send_word(ACT_ALLOC, 17'($urandom_range(65536)), $urandom);
            else if (pick < 91)
                send_word(ACT_ALLOC, 17'd0, $urandom);
            else if (pick < 95 && freed_blocks.size() > 0)
                send_word(ACT_RELEASE, 17'($urandom),
                          payload_of(freed_blocks[$urandom_range(freed_blocks.size() - 1)]));
            else if (pick < 97 && live_blocks.size() > 0)
            begin
                a = live_addr() + 32'($urandom_range(1, 7));
                send_word(ACT_RELEASE, 17'($urandom), a);
            end
            else
                send_word(ACT_RELEASE, 17'($urandom), $urandom);
        end
        stop_sending();
        drain();
    endtask

    task automatic test_hold_until_empty();
        test_random(20, 0, 0);
        idle_pct = 0;
        send_word(ACT_ALLOC, 17'd40, 32'd0);
        stop_sending();
        // The sender holds off here until the last response has been read.
        drain();
        send_word(ACT_ALLOC, 17'd8, 32'd0);
        stop_sending();
        drain();
    endtask

    // Response checker.
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (grants_due.size() == 0)
            begin
                err_count++;
                if (err_count <= ERR_PRINT_MAX)
                    $display("%0t: unexpected response address=%h ok=%b",
                             $time, rsp.address, rsp.ok);
            end
            else
            begin
                if (rsp.address !== grants_due[0].address || rsp.ok !== grants_due[0].ok)
                begin
                    err_count++;
                    if (err_count <= ERR_PRINT_MAX)
                        $display("%0t: expected address=%h ok=%b, actual address=%h ok=%b",
                                 $time, grants_due[0].address, grants_due[0].ok,
                                 rsp.address, rsp.ok);
                end
                void'(grants_due.pop_front());
            end
        end
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_first_fit_free_list_allocator failed");
            $finish;
        end
    end

    initial
    begin
        err_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 32'd0;
        req.valid = 1'b0;
        req.action = ACT_ALLOC;
        req.request_bytes = '0;
        req.release_address = 32'd0;
        rsp.ready = 1'b0;
        heap_reset_image();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(32'h0000_0000);
        test_directed();
        drain();
        write_base(32'h1000_0000);
        test_directed();
        drain();
        test_random(300, 0, 0);
        write_base(32'hFFFF_FFFC);
        test_random(60, 0, 0);
        write_base(32'hFFFF_0000);
        test_random(300, 83, 0);
        write_base(32'h8000_0004);
        test_random(300, 0, 83);
        write_base(32'h0000_1000);
        test_random(300, 37, 37);
        test_hold_until_empty();

        drain();
        repeat (100) @(posedge clk);
        if (err_count == 0 && grants_due.size() == 0)
            $display("tb_first_fit_free_list_allocator passed");
        else
            $display("tb_first_fit_free_list_allocator failed");
        $finish;
    end
endmodule
